// ===== design/trsa_pkg.sv =====
// trsa_pkg: shared types, widths and helpers for the toy rsa block decrypter
// used by trsa_div, toy_rsa_block_decrypt and trsa_chk; no dependencies
`timescale 1ns / 1ps
package trsa_pkg;

	localparam int RegW = 14;
	localparam int DvdW = 2 * RegW;
	localparam int TW   = 16;
	localparam int AddrW = 3;
	localparam int DataW = 32;
	localparam int TrialW = 8;
	localparam logic [RegW-1:0] RstExponent = RegW'(1);
	localparam logic [RegW-1:0] RstModulus  = RegW'(6);
	localparam logic [RegW-1:0] PlainMod    = RegW'(10000);
	localparam logic [RegW-1:0] PairBase    = RegW'(100);
	// floor(m / 100) = (m * 5243) >> 19 for every m below 10000
	localparam logic [RegW-1:0] PairRecip   = RegW'(5243);
	localparam int PairShift = 19;
	localparam logic [6:0] LastLetter = 7'd26;
	localparam logic [6:0] SpaceCode  = 7'd27;
	localparam logic [6:0] AsciiSpace = 7'h20;
	localparam logic [6:0] AsciiBase  = 7'h60;
	localparam logic RegExponent = 1'b0;
	localparam logic RegModulus  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_K_INIT, ST_K_SQ, ST_K_CMP, ST_K_FDIV, ST_K_PCHK, ST_K_QDIV,
		ST_K_PHI, ST_K_PHIW, ST_K_EDIV, ST_K_EU, ST_K_EDIV2, ST_K_EMUL, ST_K_EUPD,
		ST_K_FIN, ST_D_RED, ST_D_REDW, ST_D_LOOP, ST_D_AM, ST_D_AD, ST_D_ADW,
		ST_D_BM, ST_D_BD, ST_D_BDW, ST_D_M, ST_D_MW, ST_DONE
	} state_t;

	typedef struct packed {
		logic            start;
		logic [DvdW-1:0] dividend;
		logic [RegW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DvdW-1:0] quot;
		logic [RegW-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       valid;
	} pair_t;

	// decimal pair code to character
	function automatic pair_t pair_char(input logic [6:0] code);
		pair_t r;
		r.ch = '0;
		r.valid = 1'b0;
		if (code >= 7'd1 && code <= LastLetter) begin
			r.ch = AsciiBase + code;
			r.valid = 1'b1;
		end else if (code == SpaceCode) begin
			r.ch = AsciiSpace;
			r.valid = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== design/trsa_div.sv =====
// trsa_div: radix-2 restoring divider, one quotient bit per cycle
// depends on trsa_pkg for widths and request/response structs
`timescale 1ns / 1ps
module trsa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  trsa_pkg::div_req_t req,
	output trsa_pkg::div_rsp_t rsp
);
	import trsa_pkg::*;

	localparam int CntW = $clog2(DvdW);

	logic            busy_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [DvdW-1:0] dvd_q;
	logic [RegW-1:0] rem_q;
	logic [RegW-1:0] dvs_q;
	logic [RegW:0]   shifted;
	logic [RegW+1:0] diff;
	logic            ge;

	// trial subtract of the divisor from the partial remainder
	always_comb begin
		shifted = {rem_q, dvd_q[DvdW-1]};
		diff = {1'b0, shifted} - {2'b0, dvs_q};
		ge = !diff[RegW+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DvdW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RegW-1:0] : shifted[RegW-1:0];
			dvd_q <= {dvd_q[DvdW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem = rem_q;

endmodule

// ===== design/toy_rsa_block_decrypt.sv =====
// toy_rsa_block_decrypt: rsa key derivation and block decryption on one
// shared multiplier and one shared divider (trsa_div), depends on trsa_pkg
`timescale 1ns / 1ps
// a divide runs as start, one step per dividend bit, result; a multiply is registered
// per word: reduce the block mod n, then a squaring per zero and a multiply and a squaring per one exponent bit
// first word after reset or a register write also derives the key: up to 126
// trial divisions, then euclid steps
// one word at a time; a finished word waits in the output register
// async reset: registers to exponent 1, modulus 6, key not yet derived
module toy_rsa_block_decrypt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [trsa_pkg::AddrW-1:0] paddr,
	input  logic [trsa_pkg::DataW-1:0] pwdata,
	output logic [trsa_pkg::DataW-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [trsa_pkg::RegW-1:0]  cipher_block,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [6:0]                 first_char,
	output logic                       first_valid,
	output logic [6:0]                 second_char,
	output logic                       second_valid,
	output logic                       key_error
);
	import trsa_pkg::*;

	state_t state_q, state_d;
	div_req_t dreq;
	div_rsp_t drsp;

	logic [RegW-1:0] e_q, n_q;
	logic key_ok_q, key_err_q;
	logic [RegW-1:0] dexp_q, q_q, phi_q, r0_q, r1_q, k_q, rn_q;
	logic [TrialW-1:0] dtr_q, p_q;
	logic signed [TW-1:0] t0_q, t1_q, tn, tfix;
	logic [RegW-1:0] c_q, base_q, acc_q, esh_q, m_red;
	logic signed [TW-1:0] mul_a, mul_b;
	logic signed [2*TW-1:0] prod_q;
	logic [6:0] pq;
	logic [RegW-1:0] pr;
	pair_t pa1, pa2;
	logic [6:0] pc1_q, pc2_q;
	logic pv1_q, pv2_q, perr_q;
	logic out_valid_q;
	logic cfg_wr;

	trsa_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegExponent: prdata = DataW'(e_q);
			RegModulus:  prdata = DataW'(n_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= RstExponent;
			n_q <= RstModulus;
		end else if (cfg_wr) begin
			if (paddr[2] == RegModulus) n_q <= pwdata[RegW-1:0];
			else e_q <= pwdata[RegW-1:0];
		end
	end

	// shared multiplier, registered
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_K_SQ: begin
				mul_a = TW'(dtr_q);
				mul_b = TW'(dtr_q);
			end
			ST_K_PHI: begin
				mul_a = TW'(p_q - 1'b1);
				mul_b = TW'(q_q - 1'b1);
			end
			ST_K_EMUL: begin
				mul_a = TW'(k_q);
				mul_b = t1_q;
			end
			ST_D_AM: begin
				mul_a = TW'(acc_q);
				mul_b = TW'(base_q);
			end
			ST_D_BM: begin
				mul_a = TW'(base_q);
				mul_b = TW'(base_q);
			end
			ST_D_M: begin
				mul_a = TW'(m_red);
				mul_b = TW'(PairRecip);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) prod_q <= mul_a * mul_b;

	assign tn = t0_q - prod_q[TW-1:0];
	assign tfix = t0_q[TW-1] ? t0_q + TW'(phi_q) : t0_q;
	assign m_red = (acc_q >= PlainMod) ? acc_q - PlainMod : acc_q;
	// split into decimal pairs by reciprocal multiply
	assign pq = prod_q[PairShift+6:PairShift];
	assign pr = m_red - RegW'(pq) * PairBase;
	assign pa1 = pair_char(pq);
	assign pa2 = pair_char(pr[6:0]);

	// divider requests
	always_comb begin
		dreq = '0;
		case (state_q)
			ST_K_CMP: begin
				dreq.dividend = DvdW'(n_q);
				dreq.divisor = RegW'(dtr_q);
			end
			ST_K_PCHK: begin
				dreq.dividend = DvdW'(n_q);
				dreq.divisor = RegW'(p_q);
			end
			ST_K_PHIW: begin
				dreq.dividend = DvdW'(e_q);
				dreq.divisor = prod_q[RegW-1:0];
			end
			ST_K_EU: begin
				dreq.dividend = DvdW'(r0_q);
				dreq.divisor = r1_q;
			end
			ST_D_RED: begin
				dreq.dividend = DvdW'(c_q);
				dreq.divisor = n_q;
			end
			ST_D_AD, ST_D_BD: begin
				dreq.dividend = prod_q[DvdW-1:0];
				dreq.divisor = n_q;
			end
			default: ;
		endcase
		dreq.start = (state_q == ST_K_CMP && prod_q[TW-1:0] <= TW'(n_q))
			|| (state_q == ST_K_PCHK && p_q != '0)
			|| state_q == ST_K_PHIW
			|| (state_q == ST_K_EU && r1_q != '0)
			|| state_q == ST_D_RED || state_q == ST_D_AD
			|| state_q == ST_D_BD;
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!key_ok_q) state_d = ST_K_INIT;
					else if (key_err_q) state_d = ST_DONE;
					else state_d = ST_D_RED;
				end
			end
			ST_K_INIT: state_d = ST_K_SQ;
			ST_K_SQ: state_d = ST_K_CMP;
			ST_K_CMP: state_d = dreq.start ? ST_K_FDIV : ST_K_PCHK;
			ST_K_FDIV: if (drsp.done) state_d = ST_K_SQ;
			ST_K_PCHK: state_d = dreq.start ? ST_K_QDIV : ST_DONE;
			ST_K_QDIV: if (drsp.done) state_d = ST_K_PHI;
			ST_K_PHI: state_d = ST_K_PHIW;
			ST_K_PHIW: state_d = ST_K_EDIV;
			ST_K_EDIV: if (drsp.done) state_d = ST_K_EU;
			ST_K_EU: state_d = dreq.start ? ST_K_EDIV2 : ST_K_FIN;
			ST_K_EDIV2: if (drsp.done) state_d = ST_K_EMUL;
			ST_K_EMUL: state_d = ST_K_EUPD;
			ST_K_EUPD: state_d = ST_K_EU;
			ST_K_FIN: state_d = (r0_q != RegW'(1)) ? ST_DONE : ST_D_RED;
			ST_D_RED: state_d = ST_D_REDW;
			ST_D_REDW: if (drsp.done) state_d = ST_D_LOOP;
			ST_D_LOOP: begin
				if (esh_q == '0) state_d = ST_D_M;
				else if (esh_q[0]) state_d = ST_D_AM;
				else state_d = ST_D_BM;
			end
			ST_D_AM: state_d = ST_D_AD;
			ST_D_AD: state_d = ST_D_ADW;
			ST_D_ADW: if (drsp.done) state_d = ST_D_BM;
			ST_D_BM: state_d = ST_D_BD;
			ST_D_BD: state_d = ST_D_BDW;
			ST_D_BDW: if (drsp.done) state_d = ST_D_LOOP;
			ST_D_M: state_d = ST_D_MW;
			ST_D_MW: state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// key cache flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_ok_q <= 1'b0;
			key_err_q <= 1'b0;
		end else if (cfg_wr) begin
			key_ok_q <= 1'b0;
		end else if (state_q == ST_K_PCHK && p_q == '0) begin
			key_ok_q <= 1'b1;
			key_err_q <= 1'b1;
		end else if (state_q == ST_K_FIN) begin
			key_ok_q <= 1'b1;
			key_err_q <= (r0_q != RegW'(1));
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				c_q <= cipher_block;
				perr_q <= key_err_q;
				pc1_q <= '0;
				pv1_q <= 1'b0;
				pc2_q <= '0;
				pv2_q <= 1'b0;
			end
			ST_K_INIT: begin
				dtr_q <= TrialW'(2);
				p_q <= '0;
			end
			ST_K_FDIV: if (drsp.done) begin
				if (drsp.rem == '0) p_q <= dtr_q;
				dtr_q <= dtr_q + 1'b1;
			end
			ST_K_PCHK: if (p_q == '0) perr_q <= 1'b1;
			ST_K_QDIV: if (drsp.done) q_q <= drsp.quot[RegW-1:0];
			ST_K_PHIW: phi_q <= prod_q[RegW-1:0];
			ST_K_EDIV: if (drsp.done) begin
				r0_q <= phi_q;
				r1_q <= drsp.rem;
				t0_q <= '0;
				t1_q <= TW'(1);
			end
			ST_K_EDIV2: if (drsp.done) begin
				k_q <= drsp.quot[RegW-1:0];
				rn_q <= drsp.rem;
			end
			ST_K_EUPD: begin
				r0_q <= r1_q;
				r1_q <= rn_q;
				t0_q <= t1_q;
				t1_q <= tn;
			end
			ST_K_FIN: begin
				dexp_q <= tfix[RegW-1:0];
				perr_q <= (r0_q != RegW'(1));
			end
			ST_D_REDW: if (drsp.done) begin
				base_q <= drsp.rem;
				acc_q <= RegW'(1);
				esh_q <= dexp_q;
			end
			ST_D_ADW: if (drsp.done) acc_q <= drsp.rem;
			ST_D_BDW: if (drsp.done) begin
				base_q <= drsp.rem;
				esh_q <= esh_q >> 1;
			end
			ST_D_MW: begin
				pc1_q <= pa1.ch;
				pv1_q <= pa1.valid;
				pc2_q <= pa2.ch;
				pv2_q <= pa2.valid;
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			first_char <= pc1_q;
			first_valid <= pv1_q;
			second_char <= pc2_q;
			second_valid <= pv2_q;
			key_error <= perr_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/trsa_chk.sv =====
// trsa_chk: port-level checks for toy_rsa_block_decrypt, bound to the top
// depends on trsa_pkg for widths
`timescale 1ns / 1ps
module trsa_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [6:0]                 first_char,
	input logic                       first_valid,
	input logic [6:0]                 second_char,
	input logic                       second_valid,
	input logic                       key_error
);
	import trsa_pkg::*;

	// one word at a time
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// output word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_char)
		&& $stable(second_char) && $stable(key_error))
		else $error("output word changed while stalled");

	// key error carries no characters
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_error |-> !first_valid && !second_valid
		&& first_char == 7'd0 && second_char == 7'd0)
		else $error("characters with key error");

	// valid first character is a letter or space
	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_valid |-> first_char == AsciiSpace
		|| (first_char >= 7'h61 && first_char <= 7'h7a))
		else $error("bad first character");

endmodule

bind toy_rsa_block_decrypt trsa_chk u_trsa_chk (.*);
